[hw/rtl/fabd_pkg.sv]
package fabd_pkg;

	localparam int OUT_LANES = 4;
	localparam int LANE_CNT_BITS = 3;
	localparam int QDEPTH = 4;

	localparam logic [3:0] ST_RUN    = 4'd0;
	localparam logic [3:0] ST_OK     = 4'd1;
	localparam logic [3:0] ST_SHORT  = 4'd2;
	localparam logic [3:0] ST_MAGIC  = 4'd3;
	localparam logic [3:0] ST_SHIFT  = 4'd4;
	localparam logic [3:0] ST_TRUNC  = 4'd5;
	localparam logic [3:0] ST_LITOVF = 4'd6;
	localparam logic [3:0] ST_RANGE  = 4'd7;
	localparam logic [3:0] ST_SIZE   = 4'd8;

	localparam logic [3:0] PH_CMD       = 4'd0;
	localparam logic [3:0] PH_REF_LO    = 4'd1;
	localparam logic [3:0] PH_REF_HI    = 4'd5;
	localparam logic [3:0] PH_LIT       = 4'd9;
	localparam logic [3:0] PH_SHORT_OFS = 4'd10;
	localparam logic [3:0] PH_LONG_A    = 4'd11;
	localparam logic [3:0] PH_LONG_B    = 4'd12;
	localparam logic [3:0] PH_EXT_LEN   = 4'd13;

	localparam logic [7:0] MAGIC_0 = 8'h46;
	localparam logic [7:0] MAGIC_1 = 8'h41;
	localparam logic [7:0] MAGIC_2 = 8'h42;

	localparam logic [7:0] SHIFT_MIN = 8'd10;
	localparam logic [7:0] SHIFT_END = 8'd14;

	localparam logic [4:0] FLAG_WORD_BITS = 5'd16;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_bytes;
		logic [2:0]  byte_count;
		logic [3:0]  status;
		logic        end_of_run;
	} out_item_t;

	typedef struct packed {
		logic        is_copy;
		logic [7:0]  lit_byte;
		logic [16:0] offset;
		logic [8:0]  n;
		logic [3:0]  status;
	} job_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [16:0] flags;
		logic [4:0]  frem;
		logic [2:0]  slen;
		logic [3:0]  status;
	} dec_t;

	function automatic dec_t decode_f(
		input logic [1:0]  s0,
		input logic        pre_v0,
		input logic        pre_b,
		input logic [3:0]  ph0,
		input logic [16:0] fl0,
		input logic [4:0]  fr0,
		input logic [2:0]  sl0,
		input logic        ovf
	);
		dec_t       r;
		logic [1:0] s;
		logic       pv;
		logic       done;
		logic       bit_v;
		r.phase = ph0;
		r.flags = fl0;
		r.frem = fr0;
		r.slen = sl0;
		r.status = ST_RUN;
		s = s0;
		pv = pre_v0;
		done = 1'b0;
		bit_v = 1'b0;
		for (int i = 0; i < 5; i++) begin
			if (!done) begin
				if (pv) begin
					bit_v = pre_b;
					pv = 1'b0;
				end else if (r.frem <= 5'd1) begin
					r.frem = 5'd0;
					r.phase = PH_REF_LO + {2'b00, s};
					done = 1'b1;
				end else begin
					r.frem = r.frem - 5'd1;
					bit_v = r.flags[0];
					r.flags = {1'b0, r.flags[16:1]};
				end
				if (!done) begin
					case (s)
						2'd0: begin
							if (bit_v) begin
								if (ovf) r.status = ST_LITOVF;
								else r.phase = PH_LIT;
								done = 1'b1;
							end else begin
								s = 2'd1;
							end
						end
						2'd1: begin
							if (bit_v) begin
								r.phase = PH_LONG_A;
								done = 1'b1;
							end else begin
								s = 2'd2;
							end
						end
						2'd2: begin
							r.slen = {1'b0, bit_v, 1'b0};
							s = 2'd3;
						end
						default: begin
							r.slen = r.slen | {2'b00, bit_v};
							r.phase = PH_SHORT_OFS;
							done = 1'b1;
						end
					endcase
				end
			end
		end
		return r;
	endfunction

endpackage

[hw/rtl/bitflag_lz_window_decompressor.sv]
// Byte-serial decompressor for the bit-flag LZ window scheme. One compressed byte is
// accepted per cycle while the command queue (4 entries) has room and no final status is
// set; the decoder classifies it and queues one job. The executor writes a literal as it
// pops the job and streams a copy through the history RAM (one read, one write port) with a
// read and a write state per byte and an emit state per result of up to four bytes. Results
// leave through a one-entry output register, which may stall. No clearing pass follows reset.
module bitflag_lz_window_decompressor #(
	parameter int WINDOW_BYTES = 8192,
	parameter int COUNT_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  fabd_pkg::in_item_t  in_data,
	output logic                empty,
	input  logic                pop,
	output fabd_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [23:0]    exp_q;
	logic           job_push;
	logic           job_full;
	logic           job_pop;
	logic           job_empty;
	fabd_pkg::job_t job_in;
	fabd_pkg::job_t job_out;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {8'd0, exp_q} : 32'd0;
	assign full = job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) exp_q <= 24'd0;
		else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) exp_q <= pwdata[23:0];
	end

	fabd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_data (in_data),
		.size_lim(exp_q),
		.job_full(job_full),
		.job_push(job_push),
		.job     (job_in)
	);

	fabd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.din   (job_in),
		.full  (job_full),
		.pop   (job_pop),
		.empty (job_empty),
		.dout  (job_out)
	);

	fabd_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job      (job_out),
		.job_pop  (job_pop),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

endmodule

[hw/rtl/fabd_ram.sv]
module fabd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/fabd_front.sv]
module fabd_front #(
	parameter int COUNT_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fabd_pkg::in_item_t in_data,
	input  logic [23:0]       size_lim,
	input  logic              job_full,
	output logic              job_push,
	output fabd_pkg::job_t    job
);

	logic [2:0]            hdr_pos_q;
	logic [3:0]            phase_q;
	logic [16:0]           flags_q;
	logic [4:0]            frem_q;
	logic [3:0]            shift_q;
	logic [7:0]            ofs_lo_q;
	logic [7:0]            ofs_hi_q;
	logic [2:0]            slen_q;
	logic [COUNT_BITS-1:0] prod_q;
	logic                  closed_q;

	logic [2:0]            n_hdr_pos;
	logic [3:0]            n_phase;
	logic [16:0]           n_flags;
	logic [4:0]            n_frem;
	logic [3:0]            n_shift;
	logic [7:0]            n_ofs_lo;
	logic [7:0]            n_ofs_hi;
	logic [2:0]            n_slen;
	logic [COUNT_BITS-1:0] n_prod;
	logic [3:0]            st;

	logic                  do_copy;
	logic                  do_dec0;
	logic [16:0]           cdist;
	logic [8:0]            clen;
	logic [8:0]            cn;
	logic [31:0]           prod32;
	logic [31:0]           exp32;
	logic [31:0]           room;
	logic [16:0]           fl_tmp;
	logic [7:0]            b;
	fabd_pkg::dec_t        d;

	assign job_push = push && !job_full && !closed_q;
	assign b = in_data.in_byte;

	always_comb begin
		n_hdr_pos = hdr_pos_q;
		n_phase = phase_q;
		n_flags = flags_q;
		n_frem = frem_q;
		n_shift = shift_q;
		n_ofs_lo = ofs_lo_q;
		n_ofs_hi = ofs_hi_q;
		n_slen = slen_q;
		n_prod = prod_q;
		st = fabd_pkg::ST_RUN;
		do_copy = 1'b0;
		do_dec0 = 1'b0;
		cdist = 17'd0;
		clen = 9'd0;
		cn = 9'd0;
		room = 32'd0;
		fl_tmp = 17'd0;
		d = '0;
		prod32 = 32'(prod_q);
		exp32 = {8'd0, size_lim};
		job = '0;

		if (hdr_pos_q < 3'd6) begin
			if (in_data.last_byte && hdr_pos_q < 3'd5) begin
				st = fabd_pkg::ST_SHORT;
			end else begin
				case (hdr_pos_q)
					3'd0: if (b != fabd_pkg::MAGIC_0) st = fabd_pkg::ST_MAGIC;
					3'd1: if (b != fabd_pkg::MAGIC_1) st = fabd_pkg::ST_MAGIC;
					3'd2: if (b != fabd_pkg::MAGIC_2) st = fabd_pkg::ST_MAGIC;
					3'd3: begin
						if (b < fabd_pkg::SHIFT_MIN || b >= fabd_pkg::SHIFT_END)
							st = fabd_pkg::ST_SHIFT;
						else
							n_shift = b[3:0];
					end
					3'd4: n_flags = {9'd0, b};
					default: begin
						n_flags = {1'b0, b, flags_q[7:0]};
						n_frem = fabd_pkg::FLAG_WORD_BITS;
					end
				endcase
			end
			if (st == fabd_pkg::ST_RUN) begin
				n_hdr_pos = hdr_pos_q + 3'd1;
				if (hdr_pos_q == 3'd5) begin
					n_phase = fabd_pkg::PH_CMD;
					do_dec0 = 1'b1;
				end
			end
		end else if (phase_q >= fabd_pkg::PH_REF_LO && phase_q < fabd_pkg::PH_REF_HI) begin
			n_flags = {8'd0, b, flags_q[0]};
			n_phase = phase_q + 4'd4;
		end else if (phase_q >= fabd_pkg::PH_REF_HI && phase_q < fabd_pkg::PH_LIT) begin
			fl_tmp = flags_q | {b, 9'd0};
			d = fabd_pkg::decode_f(2'(phase_q - fabd_pkg::PH_REF_HI), 1'b1, fl_tmp[0],
				phase_q, {1'b0, fl_tmp[16:1]}, fabd_pkg::FLAG_WORD_BITS, slen_q,
				prod32 >= exp32);
			n_phase = d.phase;
			n_flags = d.flags;
			n_frem = d.frem;
			n_slen = d.slen;
			st = d.status;
		end else begin
			case (phase_q)
				fabd_pkg::PH_LIT: begin
					if (prod32 >= exp32) begin
						st = fabd_pkg::ST_LITOVF;
					end else begin
						job.lit_byte = b;
						job.n = 9'd1;
						n_prod = prod_q + COUNT_BITS'(1);
						do_dec0 = 1'b1;
					end
				end
				fabd_pkg::PH_SHORT_OFS: begin
					do_copy = 1'b1;
					cdist = 17'd256 - 17'(b);
					clen = 9'(slen_q) + 9'd2;
				end
				fabd_pkg::PH_LONG_A: begin
					n_ofs_lo = b;
					n_phase = fabd_pkg::PH_LONG_B;
				end
				fabd_pkg::PH_LONG_B: begin
					case (shift_q)
						4'd10: begin
							n_ofs_hi = {6'h3F, b[7:6]};
							clen = {3'd0, b[5:0]};
						end
						4'd11: begin
							n_ofs_hi = {5'h1F, b[7:5]};
							clen = {4'd0, b[4:0]};
						end
						4'd12: begin
							n_ofs_hi = {4'hF, b[7:4]};
							clen = {5'd0, b[3:0]};
						end
						default: begin
							n_ofs_hi = {3'h7, b[7:3]};
							clen = {6'd0, b[2:0]};
						end
					endcase
					if (clen == 9'd0) begin
						n_phase = fabd_pkg::PH_EXT_LEN;
					end else begin
						do_copy = 1'b1;
						clen = clen + 9'd2;
					end
					cdist = 17'h10000 - {1'b0, n_ofs_hi, ofs_lo_q};
				end
				fabd_pkg::PH_EXT_LEN: begin
					if (b == 8'd0) begin
						st = (prod32 == exp32) ? fabd_pkg::ST_OK : fabd_pkg::ST_SIZE;
					end else if (b == 8'd1) begin
						do_dec0 = 1'b1;
					end else begin
						do_copy = 1'b1;
						clen = 9'(b) + 9'd1;
						cdist = 17'h10000 - {1'b0, ofs_hi_q, ofs_lo_q};
					end
				end
				default: do_dec0 = 1'b1;
			endcase
		end

		if (do_copy) begin
			job.is_copy = 1'b1;
			job.offset = cdist;
			room = exp32 - prod32;
			if (32'(cdist) > prod32 || prod32 >= exp32) begin
				cn = 9'd0;
				st = fabd_pkg::ST_RANGE;
			end else if (32'(clen) > room) begin
				cn = room[8:0];
				st = fabd_pkg::ST_RANGE;
			end else begin
				cn = clen;
				do_dec0 = 1'b1;
			end
			job.n = cn;
			n_prod = prod_q + COUNT_BITS'(cn);
		end

		if (do_dec0) begin
			d = fabd_pkg::decode_f(2'd0, 1'b0, 1'b0, n_phase, n_flags, n_frem, n_slen,
				32'(n_prod) >= exp32);
			n_phase = d.phase;
			n_flags = d.flags;
			n_frem = d.frem;
			n_slen = d.slen;
			st = d.status;
		end

		if (st == fabd_pkg::ST_RUN && in_data.last_byte)
			st = (n_phase == fabd_pkg::PH_LIT) ? fabd_pkg::ST_LITOVF : fabd_pkg::ST_TRUNC;
		job.status = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q <= 3'd0;
			phase_q <= fabd_pkg::PH_CMD;
			flags_q <= 17'd0;
			frem_q <= fabd_pkg::FLAG_WORD_BITS;
			shift_q <= 4'd0;
			ofs_lo_q <= 8'd0;
			ofs_hi_q <= 8'd0;
			slen_q <= 3'd0;
			prod_q <= '0;
			closed_q <= 1'b0;
		end else if (job_push) begin
			hdr_pos_q <= n_hdr_pos;
			phase_q <= n_phase;
			flags_q <= n_flags;
			frem_q <= n_frem;
			shift_q <= n_shift;
			ofs_lo_q <= n_ofs_lo;
			ofs_hi_q <= n_ofs_hi;
			slen_q <= n_slen;
			prod_q <= n_prod;
			closed_q <= (st != fabd_pkg::ST_RUN);
		end
	end

endmodule

[hw/rtl/fabd_queue.sv]
module fabd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fabd_pkg::job_t din,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output fabd_pkg::job_t dout
);

	localparam int PW = $clog2(fabd_pkg::QDEPTH);

	fabd_pkg::job_t mem_q [fabd_pkg::QDEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [PW:0]    cnt_q;

	assign full = (cnt_q == (PW+1)'(fabd_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + PW'(1);
			if (pop && !empty) rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end

endmodule

[hw/rtl/fabd_back.sv]
module fabd_back #(
	parameter int WINDOW_BYTES = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_empty,
	input  fabd_pkg::job_t      job,
	output logic                job_pop,
	output logic                empty,
	input  logic                pop,
	output fabd_pkg::out_item_t out_data
);

	localparam int AW = $clog2(WINDOW_BYTES);

	typedef enum logic [1:0] {B_IDLE, B_RD, B_WR, B_EMIT} bstate_t;

	bstate_t             state_q;
	fabd_pkg::job_t      cur_q;
	logic [8:0]          rem_q;
	logic [2:0]          cnt_q;
	logic [31:0]         word_q;
	logic                fin_q;
	logic [AW-1:0]       wp_q;
	logic                oval_q;
	fabd_pkg::out_item_t out_q;

	logic                we;
	logic [7:0]          wdata;
	logic [7:0]          rdata;
	logic [AW-1:0]       raddr;
	logic                lit_go;
	logic                emit_go;

	assign job_pop = (state_q == B_IDLE) && !job_empty;
	assign lit_go = job_pop && !job.is_copy && (job.n != 9'd0);
	assign emit_go = (state_q == B_EMIT) && (!oval_q || pop);
	assign we = lit_go || (state_q == B_WR);
	assign wdata = (state_q == B_WR) ? rdata : job.lit_byte;
	assign raddr = wp_q - cur_q.offset[AW-1:0];
	assign empty = !oval_q;
	assign out_data = out_q;

	fabd_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
		.clk  (clk),
		.we   (we),
		.waddr(wp_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			oval_q <= 1'b0;
			wp_q <= '0;
			cur_q <= '0;
			rem_q <= 9'd0;
			cnt_q <= 3'd0;
			word_q <= 32'd0;
			fin_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (emit_go) oval_q <= 1'b1;
			else if (pop) oval_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						cur_q <= job;
						rem_q <= job.n;
						if (lit_go) begin
							wp_q <= wp_q + AW'(1);
							word_q <= {24'd0, job.lit_byte};
							cnt_q <= 3'd1;
							fin_q <= 1'b1;
							state_q <= B_EMIT;
						end else if (job.is_copy && job.n != 9'd0) begin
							word_q <= 32'd0;
							cnt_q <= 3'd0;
							state_q <= B_RD;
						end else begin
							word_q <= 32'd0;
							cnt_q <= 3'd0;
							fin_q <= 1'b1;
							state_q <= B_EMIT;
						end
					end
				end
				B_RD: state_q <= B_WR;
				B_WR: begin
					word_q[cnt_q[1:0]*8 +: 8] <= rdata;
					cnt_q <= cnt_q + 3'd1;
					wp_q <= wp_q + AW'(1);
					rem_q <= rem_q - 9'd1;
					if (rem_q == 9'd1) begin
						fin_q <= 1'b1;
						state_q <= B_EMIT;
					end else if (cnt_q == 3'(fabd_pkg::OUT_LANES - 1)) begin
						fin_q <= 1'b0;
						state_q <= B_EMIT;
					end else begin
						state_q <= B_RD;
					end
				end
				B_EMIT: begin
					if (emit_go) begin
						out_q.out_bytes <= word_q;
						out_q.byte_count <= cnt_q;
						out_q.status <= fin_q ? cur_q.status : fabd_pkg::ST_RUN;
						out_q.end_of_run <= fin_q;
						word_q <= 32'd0;
						cnt_q <= 3'd0;
						state_q <= fin_q ? B_IDLE : B_RD;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/fabd_checker.sv]
module fabd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input fabd_pkg::out_item_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_data))
		else $error("result dropped while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_data.byte_count <= 3'(fabd_pkg::OUT_LANES))
		else $error("byte_count out of range");

	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_data.status != fabd_pkg::ST_RUN |-> out_data.end_of_run)
		else $error("status on a result that is not the last");

	a_full_mid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !out_data.end_of_run |-> out_data.byte_count == 3'(fabd_pkg::OUT_LANES))
		else $error("partial result before end of run");

endmodule

bind bitflag_lz_window_decompressor fabd_checker u_fabd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.empty   (empty),
	.pop     (pop),
	.out_data(out_data)
);
